>>> design/sfs_pkg.sv
// Shared constants, codes and types of the sprite frame sequencer.
package sfs_pkg;

    localparam int CLIP_DEPTH = 64;
    localparam int CLIP_AW    = $clog2(CLIP_DEPTH);
    localparam int LEN_W      = 7;
    localparam int FRAME_W    = 6;
    localparam int TILE_W     = 12;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 8;
    localparam int Q_W        = 24;
    localparam int ACC_W      = 32;
    localparam int DIM_W      = 13;
    localparam int FRAC_W     = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DVD_W      = 30;
    localparam int DVS_W      = 13;
    localparam int DIV_STEPS  = DVD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int UPROD_W    = COL_W + Q_W;
    localparam int VPROD_W    = ROW_W + Q_W;

    localparam logic [Q_W-1:0]   Q_MAX            = '1;
    localparam logic [CFG_W-1:0] FRAME_PERIOD_RST = 24'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_PERIOD  = 3'd0,
        CFG_TILES_PER_ROW = 3'd1,
        CFG_CLIP_LENGTH   = 3'd2,
        CFG_SPRITE_WIDTH  = 3'd3,
        CFG_SPRITE_HEIGHT = 3'd4,
        CFG_SHEET_WIDTH   = 3'd5,
        CFG_SHEET_HEIGHT  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_READ,
        S_START,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage

>>> design/sfs_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface sfs_in_if
    import sfs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [Q_W-1:0]    elapsed;
    logic [5:0]        entry_slot;
    logic [TILE_W-1:0] entry_tile;

    modport source (output valid, func, elapsed, entry_slot, entry_tile, input ready);
    modport sink   (input valid, func, elapsed, entry_slot, entry_tile, output ready);
endinterface

interface sfs_out_if
    import sfs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_index;
    logic [TILE_W-1:0]  tile_id;
    logic [ROW_W-1:0]   tile_row;
    logic [COL_W-1:0]   tile_col;
    logic [Q_W-1:0]     u_offset;
    logic [Q_W-1:0]     v_offset;
    logic [Q_W-1:0]     u_scale;
    logic [Q_W-1:0]     v_scale;
    logic               frame_changed;

    modport source (output valid, frame_index, tile_id, tile_row, tile_col, u_offset,
                    v_offset, u_scale, v_scale, frame_changed, input ready);
    modport sink   (input valid, frame_index, tile_id, tile_row, tile_col, u_offset,
                    v_offset, u_scale, v_scale, frame_changed, output ready);
endinterface

>>> design/sfs_clip_ram.sv
// Clip table memory: one write port and one registered read port.
module sfs_clip_ram
    import sfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [CLIP_AW-1:0] i_waddr,
    input  logic [TILE_W-1:0]  i_wdata,
    input  logic               i_re,
    input  logic [CLIP_AW-1:0] i_raddr,
    output logic [TILE_W-1:0]  o_rdata
);

    logic [TILE_W-1:0] r_mem [CLIP_DEPTH];
    logic [TILE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sfs_divider.sv
// Restoring unsigned divider that retires two quotient bits per cycle.
module sfs_divider
    import sfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVS_W-1:0]     r_rem;

    logic [DVS_W:0]   n_part1;
    logic [DVS_W:0]   n_part2;
    logic             n_q1;
    logic             n_q2;
    logic [DVS_W-1:0] n_rem1;
    logic [DVS_W-1:0] n_rem2;

    always_comb begin
        n_part1 = {r_rem, r_dvd[DVD_W-1]};
        n_q1    = n_part1 >= {1'b0, r_dvs};
        n_rem1  = n_q1 ? DVS_W'(n_part1 - {1'b0, r_dvs}) : n_part1[DVS_W-1:0];
        n_part2 = {n_rem1, r_dvd[DVD_W-2]};
        n_q2    = n_part2 >= {1'b0, r_dvs};
        n_rem2  = n_q2 ? DVS_W'(n_part2 - {1'b0, r_dvs}) : n_part2[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-3:0], n_q1, n_q2};
            r_rem <= n_rem2;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_dvd;
    assign o_rsp.remainder = r_rem;

endmodule

>>> design/sprite_frame_sequencer_unit.sv
// Top level of the sprite frame sequencer: control, state registers and result stage.
//
// Input items arrive on i_item as valid/ready transactions. A tick item adds its
// elapsed time to a saturating accumulator and advances the clip frame when the
// accumulator exceeds the frame period; a load item writes one clip table entry.
// Every item yields exactly one result transaction on o_result describing the
// current frame: its tile, sheet row and column, texture offset and scale.
// The block handles one item at a time. The accumulator add happens at the
// accepting edge. After acceptance the item passes through these states in
// order: the period compare and frame advance, the clip table read, the launch
// of the dividers, the shared-length division (tile by tiles per row, and the
// two scale ratios, 15 steps of two bits in parallel, then a completion signal),
// the offset multiplies and the load of the result register. A new item can be
// accepted in the cycle after the result register is loaded, so the block takes
// no new item before the last one is through, while that result may still wait
// for the receiver. When the receiver stalls, the finished result is held, and
// the next item is processed up to the result stage and waits there.
// Reset clears the accumulator and the frame index and sets the configuration to
// its reset values; the clip table is not cleared and must be loaded before it
// is read. Configuration writes are taken on any cycle.
module sprite_frame_sequencer_unit
    import sfs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    sfs_in_if.sink               i_item,
    sfs_out_if.source            o_result
);

    // Configuration registers.
    logic [Q_W-1:0]   r_frame_period;
    logic [COL_W-1:0] r_tiles_per_row;
    logic [LEN_W-1:0] r_clip_length;
    logic [DIM_W-1:0] r_sprite_width;
    logic [DIM_W-1:0] r_sprite_height;
    logic [DIM_W-1:0] r_sheet_width;
    logic [DIM_W-1:0] r_sheet_height;

    // Control and working state.
    t_state             r_state;
    t_state             n_state;
    logic [ACC_W-1:0]   r_accum;
    logic [FRAME_W-1:0] r_frame;
    logic               r_func;
    logic               r_changed;
    logic               r_in_clip;
    logic [TILE_W-1:0]  r_tile;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [Q_W-1:0]     r_u_scale;
    logic [Q_W-1:0]     r_v_scale;
    logic [UPROD_W-1:0] r_uprod;
    logic [VPROD_W-1:0] r_vprod;

    // Result register.
    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_frame;
    logic [TILE_W-1:0]  r_out_tile;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic [Q_W-1:0]     r_out_uoff;
    logic [Q_W-1:0]     r_out_voff;
    logic [Q_W-1:0]     r_out_uscale;
    logic [Q_W-1:0]     r_out_vscale;
    logic               r_out_changed;

    // Strobes from the state machine.
    logic in_ready;
    logic ram_re;
    logic div_start;
    logic out_load;

    logic               accept;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   frame_inc;
    logic [ACC_W:0]     acc_sum;
    logic [COL_W-1:0]   eff_per;
    logic [TILE_W-1:0]  ram_rdata;
    logic [TILE_W-1:0]  tile_sel;
    logic               out_free;

    t_div_req tile_req;
    t_div_req u_req;
    t_div_req v_req;
    t_div_rsp tile_rsp;
    t_div_rsp u_rsp;
    t_div_rsp v_rsp;

    assign accept    = i_item.valid && in_ready;
    assign eff_len   = (r_clip_length > LEN_W'(CLIP_DEPTH)) ? LEN_W'(CLIP_DEPTH)
                                                            : r_clip_length;
    assign frame_inc = LEN_W'({1'b0, r_frame}) + LEN_W'(1);
    assign acc_sum   = {1'b0, r_accum} + (ACC_W + 1)'(i_item.elapsed);
    assign eff_per   = (r_tiles_per_row == '0) ? COL_W'(1) : r_tiles_per_row;
    assign tile_sel  = (LEN_W'({1'b0, r_frame}) < eff_len) ? ram_rdata : '0;
    assign out_free  = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period  <= FRAME_PERIOD_RST;
            r_tiles_per_row <= COL_W'(1);
            r_clip_length   <= '0;
            r_sprite_width  <= DIM_W'(1);
            r_sprite_height <= DIM_W'(1);
            r_sheet_width   <= DIM_W'(1);
            r_sheet_height  <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_PERIOD:  r_frame_period  <= i_cfg_data[Q_W-1:0];
                CFG_TILES_PER_ROW: r_tiles_per_row <= i_cfg_data[COL_W-1:0];
                CFG_CLIP_LENGTH:   r_clip_length   <= i_cfg_data[LEN_W-1:0];
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[DIM_W-1:0];
                CFG_SHEET_WIDTH:   r_sheet_width   <= i_cfg_data[DIM_W-1:0];
                CFG_SHEET_HEIGHT:  r_sheet_height  <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_item.valid) n_state = S_ADV;
            S_ADV:   n_state = S_READ;
            S_READ:  n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (u_rsp.done && v_rsp.done && tile_rsp.done) n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE:  in_ready  = 1'b1;
            S_READ:  ram_re    = 1'b1;
            S_START: div_start = 1'b1;
            S_OUT:   out_load  = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accum     <= '0;
            r_frame     <= '0;
            r_changed   <= 1'b0;
            r_func      <= FUNC_TICK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_func    <= i_item.func;
                r_changed <= 1'b0;
                if (t_func'(i_item.func) == FUNC_TICK) begin
                    r_accum <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                end
            end
            if (r_state == S_ADV && t_func'(r_func) == FUNC_TICK
                    && r_accum > ACC_W'(r_frame_period)) begin
                r_accum <= r_accum - ACC_W'(r_frame_period);
                if (eff_len != '0) begin
                    r_frame   <= (frame_inc >= eff_len) ? '0 : frame_inc[FRAME_W-1:0];
                    r_changed <= 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_tile    <= tile_sel;
            r_in_clip <= LEN_W'({1'b0, r_frame}) < eff_len;
        end
        if (r_state == S_DIV && tile_rsp.done) begin
            r_row     <= r_in_clip ? tile_rsp.quotient[ROW_W-1:0] : '0;
            r_col     <= r_in_clip ? tile_rsp.remainder[COL_W-1:0] : '0;
            r_u_scale <= (u_rsp.quotient > DVD_W'(Q_MAX)) ? Q_MAX : u_rsp.quotient[Q_W-1:0];
            r_v_scale <= (v_rsp.quotient > DVD_W'(Q_MAX)) ? Q_MAX : v_rsp.quotient[Q_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_uprod <= UPROD_W'(r_col) * UPROD_W'(r_u_scale);
            r_vprod <= VPROD_W'(r_row) * VPROD_W'(r_v_scale);
        end
        if (out_load) begin
            r_out_frame   <= r_frame;
            r_out_tile    <= r_tile;
            r_out_row     <= r_row;
            r_out_col     <= r_col;
            r_out_uoff    <= (r_uprod > UPROD_W'(Q_MAX)) ? Q_MAX : r_uprod[Q_W-1:0];
            r_out_voff    <= (r_vprod > VPROD_W'(Q_MAX)) ? Q_MAX : r_vprod[Q_W-1:0];
            r_out_uscale  <= r_u_scale;
            r_out_vscale  <= r_v_scale;
            r_out_changed <= r_changed;
        end
    end

    sfs_clip_ram u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (accept && t_func'(i_item.func) == FUNC_LOAD
                  && int'(i_item.entry_slot) < CLIP_DEPTH),
        .i_waddr (CLIP_AW'(i_item.entry_slot)),
        .i_wdata (i_item.entry_tile),
        .i_re    (ram_re),
        .i_raddr (CLIP_AW'(r_frame)),
        .o_rdata (ram_rdata)
    );

    assign tile_req.start    = div_start;
    assign tile_req.dividend = DVD_W'(tile_sel);
    assign tile_req.divisor  = DVS_W'(eff_per);

    assign u_req.start    = div_start;
    assign u_req.dividend = DVD_W'({r_sprite_width, {FRAC_W{1'b0}}});
    assign u_req.divisor  = r_sheet_width;

    assign v_req.start    = div_start;
    assign v_req.dividend = DVD_W'({r_sprite_height, {FRAC_W{1'b0}}});
    assign v_req.divisor  = r_sheet_height;

    sfs_divider u_tile_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tile_req),
        .o_rsp   (tile_rsp)
    );

    sfs_divider u_uscale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_rsp   (u_rsp)
    );

    sfs_divider u_vscale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (v_req),
        .o_rsp   (v_rsp)
    );

    assign i_item.ready = in_ready;

    assign o_result.valid         = r_out_valid;
    assign o_result.frame_index   = r_out_frame;
    assign o_result.tile_id       = r_out_tile;
    assign o_result.tile_row      = r_out_row;
    assign o_result.tile_col      = r_out_col;
    assign o_result.u_offset      = r_out_uoff;
    assign o_result.v_offset      = r_out_voff;
    assign o_result.u_scale       = r_out_uscale;
    assign o_result.v_scale       = r_out_vscale;
    assign o_result.frame_changed = r_out_changed;

endmodule
